@@ hdl/vnu_pkg.sv @@
// Shared widths and the pipeline payload type of the vector normalize unit.
`timescale 1ns / 1ps
package vnu_pkg;
	localparam int IN_W   = 16;              // input component width
	localparam int FRAC   = 14;              // fraction bits of the result
	localparam int OUT_W  = FRAC + 2;        // result component width
	localparam int LANES  = 3;               // one lane per component
	localparam int SQ_W   = 2 * IN_W;        // square and sum of squares
	localparam int N_W    = SQ_W + 2 * FRAC; // sum scaled by 2^(2*FRAC)
	localparam int RT_W   = N_W / 2;         // square root width
	localparam int RM_W   = RT_W + 2;        // square root remainder width
	localparam int NUM_W  = IN_W + 2 * FRAC; // dividend width
	localparam int Q_W    = FRAC + 1;        // quotient width
	localparam int STAGES = RT_W + Q_W + 3;  // squares, sum, root, divide, output

	typedef struct packed {
		logic                            zero;
		logic [LANES-1:0]                neg;
		logic [LANES-1:0][IN_W-1:0]      mag;
		logic [LANES-1:0][SQ_W-1:0]      sq;
		logic [SQ_W-1:0]                 s;
		logic [RT_W-1:0]                 root;
		logic [RM_W-1:0]                 rem;
		logic [LANES-1:0][NUM_W-1:0]     part;
		logic [LANES-1:0][Q_W-1:0]       quo;
		logic [LANES-1:0][OUT_W-1:0]     res;
	} pipe_t;
endpackage

@@ hdl/vnu_if.sv @@
// Valid/ready channel interfaces for input vectors and normalized results.
`timescale 1ns / 1ps
interface vnu_in_if;
	logic                              valid;
	logic                              ready;
	logic signed [vnu_pkg::IN_W-1:0]   x_in;
	logic signed [vnu_pkg::IN_W-1:0]   y_in;
	logic signed [vnu_pkg::IN_W-1:0]   z_in;
	modport source (output valid, x_in, y_in, z_in, input ready);
	modport sink (input valid, x_in, y_in, z_in, output ready);
endinterface

interface vnu_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [vnu_pkg::OUT_W-1:0]  x_out;
	logic signed [vnu_pkg::OUT_W-1:0]  y_out;
	logic signed [vnu_pkg::OUT_W-1:0]  z_out;
	logic                              zero_length;
	modport source (output valid, x_out, y_out, z_out, zero_length, input ready);
	modport sink (input valid, x_out, y_out, z_out, zero_length, output ready);
endinterface

@@ hdl/vnu_sqrt_step.sv @@
// One digit step of the restoring integer square root.
`timescale 1ns / 1ps
module vnu_sqrt_step (
	input  logic [vnu_pkg::RM_W-1:0] rem_i,
	input  logic [vnu_pkg::RT_W-1:0] root_i,
	input  logic [1:0]               pair_i,
	output logic [vnu_pkg::RM_W-1:0] rem_o,
	output logic [vnu_pkg::RT_W-1:0] root_o
);
	logic [vnu_pkg::RM_W+1:0] shifted;
	logic [vnu_pkg::RM_W+1:0] trial;
	logic [vnu_pkg::RM_W+1:0] diff;
	logic                     take;

	always_comb begin
		shifted = {rem_i, pair_i};
		trial   = {2'b00, root_i, 2'b01};
		diff    = shifted - trial;
		take    = (shifted >= trial);
		// The remainder never exceeds twice the root, so it fits RM_W bits.
		rem_o   = take ? diff[vnu_pkg::RM_W-1:0] : shifted[vnu_pkg::RM_W-1:0];
		root_o  = {root_i[vnu_pkg::RT_W-2:0], take};
	end
endmodule

@@ hdl/vnu_div_step.sv @@
// One quotient bit of a restoring divider lane.
`timescale 1ns / 1ps
module vnu_div_step (
	input  logic [vnu_pkg::NUM_W-1:0] part_i,
	input  logic [vnu_pkg::NUM_W-1:0] dsh_i,
	output logic [vnu_pkg::NUM_W-1:0] part_o,
	output logic                      bit_o
);
	always_comb begin
		bit_o  = (part_i >= dsh_i);
		part_o = bit_o ? (part_i - dsh_i) : part_i;
	end
endmodule

@@ hdl/vector3_normalize_unit.sv @@
// Top level of the pipelined 3D vector normalize unit.
`timescale 1ns / 1ps
// The unit takes one signed vector (x_in, y_in, z_in) per beat and returns
// its unit vector in signed Q1.14, each component truncated toward zero and
// never above 16384 in magnitude. An all-zero vector returns zeros with
// zero_length set. A new beat is accepted every clock cycle while the output
// side takes every beat. A result passes through the stage chain: one stage
// of squaring, one sum, 30 square root digit stages, 15 quotient bit stages
// in three parallel divider lanes, and one output stage. Every stage advances
// on its own when it is empty or its successor moves, so a stalled result at
// the output does not stop upstream stages from filling their bubbles.
module vector3_normalize_unit (
	input  logic      clk,
	input  logic      arst_n,
	vnu_in_if.sink    in_vec,
	vnu_out_if.source out_vec
);
	localparam int L  = vnu_pkg::STAGES;
	localparam int RS = 2;                         // first square root stage
	localparam int DS = RS + vnu_pkg::RT_W;        // first divide stage
	localparam int OS = DS + vnu_pkg::Q_W;         // output stage

	vnu_pkg::pipe_t pipe_s [L];
	vnu_pkg::pipe_t nxt    [L];
	logic [L-1:0]   vld_q;
	logic [L-1:0]   adv;

	// A stage loads when it is empty or its content moves on.
	always_comb begin
		adv[L-1] = !vld_q[L-1] || out_vec.ready;
		for (int k = L - 2; k >= 0; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	assign in_vec.ready = adv[0];

	// Stage 1: magnitudes, signs and squares for each lane.
	logic [vnu_pkg::LANES-1:0][vnu_pkg::IN_W-1:0] comp;
	assign comp = {in_vec.z_in, in_vec.y_in, in_vec.x_in};

	always_comb begin
		nxt[0] = '0;
		for (int l = 0; l < vnu_pkg::LANES; l++) begin
			nxt[0].neg[l] = comp[l][vnu_pkg::IN_W-1];
			nxt[0].mag[l] = comp[l][vnu_pkg::IN_W-1] ? (~comp[l] + 1'b1) : comp[l];
			nxt[0].sq[l]  = vnu_pkg::SQ_W'(nxt[0].mag[l]) * vnu_pkg::SQ_W'(nxt[0].mag[l]);
		end
	end

	// Stage 2: the lanes merge into the sum of squares.
	always_comb begin
		nxt[1]      = pipe_s[0];
		nxt[1].s    = pipe_s[0].sq[0] + pipe_s[0].sq[1] + pipe_s[0].sq[2];
		nxt[1].zero = (nxt[1].s == '0);
		nxt[1].root = '0;
		nxt[1].rem  = '0;
	end

	// Square root of the scaled sum, one digit per stage.
	for (genvar j = 0; j < vnu_pkg::RT_W; j++) begin : g_root
		logic [vnu_pkg::N_W-1:0]  scaled;
		logic [vnu_pkg::RM_W-1:0] rem_n;
		logic [vnu_pkg::RT_W-1:0] root_n;

		assign scaled = {pipe_s[RS+j-1].s, {(2 * vnu_pkg::FRAC){1'b0}}};

		vnu_sqrt_step u_step (
			.rem_i  (pipe_s[RS+j-1].rem),
			.root_i (pipe_s[RS+j-1].root),
			.pair_i (scaled[2*(vnu_pkg::RT_W-1-j) +: 2]),
			.rem_o  (rem_n),
			.root_o (root_n)
		);

		always_comb begin
			nxt[RS+j]      = pipe_s[RS+j-1];
			nxt[RS+j].rem  = rem_n;
			nxt[RS+j].root = root_n;
			if (j == vnu_pkg::RT_W - 1) begin
				for (int l = 0; l < vnu_pkg::LANES; l++) begin
					nxt[RS+j].part[l] = {pipe_s[RS+j-1].mag[l], {(2 * vnu_pkg::FRAC){1'b0}}};
					nxt[RS+j].quo[l]  = '0;
				end
			end
		end
	end

	// Three divider lanes, one quotient bit per stage.
	for (genvar j = 0; j < vnu_pkg::Q_W; j++) begin : g_div
		logic [vnu_pkg::NUM_W-1:0]                     dsh;
		logic [vnu_pkg::LANES-1:0][vnu_pkg::NUM_W-1:0] part_n;
		logic [vnu_pkg::LANES-1:0]                     bit_n;

		assign dsh = vnu_pkg::NUM_W'(pipe_s[DS+j-1].root) << (vnu_pkg::Q_W - 1 - j);

		for (genvar l = 0; l < vnu_pkg::LANES; l++) begin : g_lane
			vnu_div_step u_step (
				.part_i (pipe_s[DS+j-1].part[l]),
				.dsh_i  (dsh),
				.part_o (part_n[l]),
				.bit_o  (bit_n[l])
			);
		end

		always_comb begin
			nxt[DS+j] = pipe_s[DS+j-1];
			for (int l = 0; l < vnu_pkg::LANES; l++) begin
				nxt[DS+j].part[l] = part_n[l];
				nxt[DS+j].quo[l]  = {pipe_s[DS+j-1].quo[l][vnu_pkg::Q_W-2:0], bit_n[l]};
			end
		end
	end

	// Output stage: clamp, restore the sign and force zeros for a zero vector.
	always_comb begin
		logic [vnu_pkg::OUT_W-1:0] q;
		q       = '0;
		nxt[OS] = pipe_s[OS-1];
		for (int l = 0; l < vnu_pkg::LANES; l++) begin
			q = vnu_pkg::OUT_W'(pipe_s[OS-1].quo[l]);
			if (q > (vnu_pkg::OUT_W'(1) << vnu_pkg::FRAC)) begin
				q = vnu_pkg::OUT_W'(1) << vnu_pkg::FRAC;
			end
			if (pipe_s[OS-1].zero) begin
				nxt[OS].res[l] = '0;
			end else begin
				nxt[OS].res[l] = pipe_s[OS-1].neg[l] ? (~q + 1'b1) : q;
			end
		end
	end

	for (genvar k = 0; k < L; k++) begin : g_reg
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (adv[k]) begin
				vld_q[k] <= (k == 0) ? in_vec.valid : vld_q[(k == 0) ? 0 : k - 1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv[k]) begin
				pipe_s[k] <= nxt[k];
			end
		end
	end

	assign out_vec.valid       = vld_q[L-1];
	assign out_vec.x_out       = pipe_s[L-1].res[0];
	assign out_vec.y_out       = pipe_s[L-1].res[1];
	assign out_vec.z_out       = pipe_s[L-1].res[2];
	assign out_vec.zero_length = pipe_s[L-1].zero;

	// With the output stage empty, every stage can move, so input is taken.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_q[L-1] |-> in_vec.ready)
		else $error("input stalled while the output stage is empty");

	// A zero vector gives all-zero components.
	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vec.valid && out_vec.zero_length) |->
		(out_vec.x_out == '0 && out_vec.y_out == '0 && out_vec.z_out == '0))
		else $error("zero vector with nonzero components");

	// A nonzero vector has at least one nonzero unit component.
	a_nonzero_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vec.valid && !out_vec.zero_length) |->
		(out_vec.x_out != '0 || out_vec.y_out != '0 || out_vec.z_out != '0))
		else $error("nonzero vector normalized to all zeros");
endmodule
